[rtl/tcw_pkg.sv]
// Shared constants, field types and control-word layout for the text console writer.
// Depends on nothing; every other file refers to it by scoped names.
package tcw_pkg;

    // Geometry
    localparam int CONSOLES     = 8;
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int PLANE        = COLUMNS * ROWS;
    localparam int SCROLL_CELLS = COLUMNS * (ROWS - 1);

    localparam int CON_W  = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
    localparam int POS_W  = $clog2(PLANE);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int MEM_AW = CON_W + POS_W;
    localparam int SLOTS  = 1 << CON_W;
    localparam int CMEM_DEPTH = 1 << MEM_AW;
    localparam int SMEM_DEPTH = 1 << POS_W;

    // Word field widths
    localparam int CMD_W      = 2;
    localparam int CONSOLE_W  = 4;
    localparam int COORD_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int CUR_COL_W  = 7;
    localparam int CUR_LINE_W = 5;
    localparam int SHOWN_W    = 3;

    typedef logic [CONSOLE_W-1:0]  console_id_t;
    typedef logic [CONSOLE_W:0]    con_wide_t;
    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [CUR_COL_W-1:0]  cur_col_t;
    typedef logic [CUR_LINE_W-1:0] cur_line_t;
    typedef logic [SHOWN_W-1:0]    shown_t;
    typedef logic [2*BYTE_W-1:0]   cell_t;
    typedef logic [CON_W-1:0]      con_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [COL_W-1:0]      col_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [MEM_AW-1:0]     addr_t;

    localparam byte_t BLANK_GLYPH = 8'h20;
    localparam byte_t BLANK_COLOR = 8'h0F;
    localparam cell_t BLANK_CELL  = {BLANK_COLOR, BLANK_GLYPH};

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT_CURSOR = 2'd0,
        CMD_PUT_POS    = 2'd1,
        CMD_SELECT     = 2'd2,
        CMD_READ       = 2'd3
    } cmd_t;

    // Microprogram steps
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT_CUR,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_PUT_POS,
        ST_SELECT,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_READ_RD,
        ST_READ_CAP
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_SCROLL,
        C_SCROLL_MORE,
        C_LOAD_MORE,
        C_CLEAR_MORE
    } cond_t;

    // Source of the cell write address and data
    typedef enum logic [1:0] {
        SRC_CURSOR,
        SRC_POSITION,
        SRC_COPY,
        SRC_BLANK
    } src_t;

    typedef enum logic [1:0] {
        SM_NONE,
        SM_MIRROR,
        SM_ALWAYS
    } smode_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC
    } cnt_op_t;

    // Datapath part of a control word
    typedef struct packed {
        logic    take;
        src_t    src;
        logic    cmem_we;
        smode_t  smode;
        logic    cmem_re;
        logic    rd_ahead;
        logic    smem_re;
        cnt_op_t cnt_op;
        logic    cur_adv;
        logic    set_active;
        logic    cap_read;
        logic    set_acc;
    } ctrl_t;

    // Flags the datapath reports back to the sequencer
    typedef struct packed {
        cmd_t cmd;
        logic con_ok;
        logic pos_ok;
        logic need_scroll;
        logic scroll_more;
        logic load_more;
        logic clear_more;
    } status_t;

endpackage

[rtl/tcw_if.sv]
// Valid/ready channels of the text console writer: command words in, cell words out.
// Depends on tcw_pkg for field widths.
interface tcw_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::CMD_W-1:0]         command;
    tcw_pkg::console_id_t              console;
    tcw_pkg::coord_t                   column;
    tcw_pkg::coord_t                   row;
    tcw_pkg::byte_t                    glyph_code;
    tcw_pkg::byte_t                    color_attr;

    modport source (output valid, command, console, column, row, glyph_code, color_attr,
                    input ready);
    modport sink   (input valid, command, console, column, row, glyph_code, color_attr,
                    output ready);
endinterface

interface tcw_cell_if;
    logic                 valid;
    logic                 ready;
    tcw_pkg::byte_t       cell_glyph;
    tcw_pkg::byte_t       cell_color;
    tcw_pkg::cur_col_t    cursor_col;
    tcw_pkg::cur_line_t   cursor_line;
    tcw_pkg::shown_t      shown_console;
    logic                 accepted;

    modport source (output valid, cell_glyph, cell_color, cursor_col, cursor_line,
                    shown_console, accepted, input ready);
    modport sink   (input valid, cell_glyph, cell_color, cursor_col, cursor_line,
                    shown_console, accepted, output ready);
endinterface

[rtl/tcw_sequencer.sv]
// Microprogram store, step counter and branch logic of the text console writer.
// Depends on tcw_pkg for step codes, conditions and the control word layout.
module tcw_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  tcw_pkg::status_t status,
    input  logic             accept,
    output tcw_pkg::ctrl_t   ctrl
);

    typedef struct packed {
        tcw_pkg::cond_t cond;
        tcw_pkg::step_t jmp;
        tcw_pkg::step_t nxt;
        logic           dispatch;
    } seq_word_t;

    typedef struct packed {
        seq_word_t      seq;
        tcw_pkg::ctrl_t ctrl;
    } uword_t;

    function automatic uword_t ucode(input tcw_pkg::step_t step);
        uword_t w;
        w = '0;
        w.seq.jmp = tcw_pkg::ST_IDLE;
        w.seq.nxt = tcw_pkg::ST_IDLE;
        unique case (step)
            tcw_pkg::ST_CLEAR:
            begin
                w.ctrl.src     = tcw_pkg::SRC_BLANK;
                w.ctrl.cmem_we = 1'b1;
                w.ctrl.smode   = tcw_pkg::SM_ALWAYS;
                w.ctrl.cnt_op  = tcw_pkg::CNT_INC;
                w.seq.cond     = tcw_pkg::C_CLEAR_MORE;
                w.seq.jmp      = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::ST_IDLE:
            begin
                w.ctrl.take    = 1'b1;
                w.seq.dispatch = 1'b1;
            end
            tcw_pkg::ST_PUT_CUR:
            begin
                w.ctrl.src     = tcw_pkg::SRC_CURSOR;
                w.ctrl.cmem_we = 1'b1;
                w.ctrl.smode   = tcw_pkg::SM_MIRROR;
                w.ctrl.cur_adv = 1'b1;
                w.ctrl.cnt_op  = tcw_pkg::CNT_CLEAR;
                w.ctrl.set_acc = 1'b1;
                w.seq.cond     = tcw_pkg::C_SCROLL;
                w.seq.jmp      = tcw_pkg::ST_SCR_RD;
            end
            tcw_pkg::ST_SCR_RD:
            begin
                w.ctrl.cmem_re  = 1'b1;
                w.ctrl.rd_ahead = 1'b1;
                w.seq.jmp       = tcw_pkg::ST_SCR_WR;
                w.seq.nxt       = tcw_pkg::ST_SCR_WR;
            end
            tcw_pkg::ST_SCR_WR:
            begin
                w.ctrl.src     = tcw_pkg::SRC_COPY;
                w.ctrl.cmem_we = 1'b1;
                w.ctrl.smode   = tcw_pkg::SM_MIRROR;
                w.ctrl.cnt_op  = tcw_pkg::CNT_INC;
                w.seq.cond     = tcw_pkg::C_SCROLL_MORE;
                w.seq.jmp      = tcw_pkg::ST_SCR_RD;
            end
            tcw_pkg::ST_PUT_POS:
            begin
                w.ctrl.src     = tcw_pkg::SRC_POSITION;
                w.ctrl.cmem_we = 1'b1;
                w.ctrl.smode   = tcw_pkg::SM_MIRROR;
                w.ctrl.set_acc = 1'b1;
            end
            tcw_pkg::ST_SELECT:
            begin
                w.ctrl.set_active = 1'b1;
                w.ctrl.cnt_op     = tcw_pkg::CNT_CLEAR;
                w.ctrl.set_acc    = 1'b1;
                w.seq.jmp         = tcw_pkg::ST_LOAD_RD;
                w.seq.nxt         = tcw_pkg::ST_LOAD_RD;
            end
            tcw_pkg::ST_LOAD_RD:
            begin
                w.ctrl.cmem_re = 1'b1;
                w.seq.jmp      = tcw_pkg::ST_LOAD_WR;
                w.seq.nxt      = tcw_pkg::ST_LOAD_WR;
            end
            tcw_pkg::ST_LOAD_WR:
            begin
                w.ctrl.src    = tcw_pkg::SRC_COPY;
                w.ctrl.smode  = tcw_pkg::SM_ALWAYS;
                w.ctrl.cnt_op = tcw_pkg::CNT_INC;
                w.seq.cond    = tcw_pkg::C_LOAD_MORE;
                w.seq.jmp     = tcw_pkg::ST_LOAD_RD;
            end
            tcw_pkg::ST_READ_RD:
            begin
                w.ctrl.smem_re = 1'b1;
                w.seq.jmp      = tcw_pkg::ST_READ_CAP;
                w.seq.nxt      = tcw_pkg::ST_READ_CAP;
            end
            tcw_pkg::ST_READ_CAP:
            begin
                w.ctrl.cap_read = 1'b1;
                w.ctrl.set_acc  = 1'b1;
            end
            default:
            begin
                w.seq.jmp = tcw_pkg::ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Map a command to its routine; rejected commands go straight back to idle
    function automatic tcw_pkg::step_t dispatch_target(input tcw_pkg::cmd_t cmd,
                                                       input logic con_ok,
                                                       input logic pos_ok);
        tcw_pkg::step_t s;
        unique case (cmd)
            tcw_pkg::CMD_PUT_CURSOR: s = con_ok ? tcw_pkg::ST_PUT_CUR : tcw_pkg::ST_IDLE;
            tcw_pkg::CMD_PUT_POS:
                s = (con_ok && pos_ok) ? tcw_pkg::ST_PUT_POS : tcw_pkg::ST_IDLE;
            tcw_pkg::CMD_SELECT:     s = con_ok ? tcw_pkg::ST_SELECT : tcw_pkg::ST_IDLE;
            tcw_pkg::CMD_READ:       s = pos_ok ? tcw_pkg::ST_READ_RD : tcw_pkg::ST_IDLE;
        endcase
        return s;
    endfunction

    tcw_pkg::step_t step_reg;
    tcw_pkg::step_t step_next;
    uword_t         uw;
    logic           cond_hit;

    always_comb
    begin
        uw   = ucode(step_reg);
        ctrl = uw.ctrl;
        unique case (uw.seq.cond)
            tcw_pkg::C_ALWAYS:      cond_hit = 1'b1;
            tcw_pkg::C_SCROLL:      cond_hit = status.need_scroll;
            tcw_pkg::C_SCROLL_MORE: cond_hit = status.scroll_more;
            tcw_pkg::C_LOAD_MORE:   cond_hit = status.load_more;
            tcw_pkg::C_CLEAR_MORE:  cond_hit = status.clear_more;
            default:                cond_hit = 1'b0;
        endcase
        if (uw.seq.dispatch && accept)
        begin
            step_next = dispatch_target(status.cmd, status.con_ok, status.pos_ok);
        end
        else
        begin
            step_next = cond_hit ? uw.seq.jmp : uw.seq.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tcw_pkg::ST_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[rtl/tcw_datapath.sv]
// Cell stores, cursors, copy counter and result register of the text console writer.
// Depends on tcw_pkg; driven one control word per cycle by tcw_sequencer.
module tcw_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::ctrl_t       ctrl,
    input  logic                 accept,
    input  logic                 emit,
    input  tcw_pkg::cmd_t        command,
    input  tcw_pkg::console_id_t console,
    input  tcw_pkg::coord_t      column,
    input  tcw_pkg::coord_t      row,
    input  tcw_pkg::byte_t       glyph_code,
    input  tcw_pkg::byte_t       color_attr,
    output tcw_pkg::status_t     status,
    output tcw_pkg::byte_t       cell_glyph,
    output tcw_pkg::byte_t       cell_color,
    output tcw_pkg::cur_col_t    cursor_col,
    output tcw_pkg::cur_line_t   cursor_line,
    output tcw_pkg::shown_t      shown_console,
    output logic                 accepted
);

    // Stores
    tcw_pkg::cell_t cmem_mem [tcw_pkg::CMEM_DEPTH];
    tcw_pkg::cell_t smem_mem [tcw_pkg::SMEM_DEPTH];
    tcw_pkg::cell_t cmem_rdata_reg;
    tcw_pkg::cell_t smem_rdata_reg;

    // Latched command word
    tcw_pkg::console_id_t con_reg;
    tcw_pkg::coord_t      col_reg;
    tcw_pkg::coord_t      row_reg;
    tcw_pkg::cell_t       cell_reg;

    // Result under construction and result register
    tcw_pkg::byte_t     glyph_reg;
    tcw_pkg::byte_t     color_reg;
    logic               acc_reg;
    tcw_pkg::byte_t     out_glyph_reg;
    tcw_pkg::byte_t     out_color_reg;
    tcw_pkg::cur_col_t  out_col_reg;
    tcw_pkg::cur_line_t out_line_reg;
    tcw_pkg::shown_t    out_shown_reg;
    logic               out_acc_reg;

    // Control state
    tcw_pkg::addr_t cnt_reg;
    tcw_pkg::addr_t cnt_next;
    tcw_pkg::con_t  active_reg;
    tcw_pkg::con_t  active_next;
    tcw_pkg::col_t  cur_col_reg [tcw_pkg::SLOTS];
    tcw_pkg::row_t  cur_row_reg [tcw_pkg::SLOTS];
    tcw_pkg::col_t  cur_col_next;
    tcw_pkg::row_t  cur_row_next;

    tcw_pkg::con_t  con_idx;
    logic           con_ok;
    tcw_pkg::col_t  cur_col;
    tcw_pkg::row_t  cur_row;
    logic           col_last;
    logic           row_last;
    tcw_pkg::pos_t  cur_pos;
    tcw_pkg::pos_t  in_pos;
    tcw_pkg::pos_t  cnt_pos;
    tcw_pkg::pos_t  rd_pos;
    tcw_pkg::addr_t wr_addr;
    tcw_pkg::pos_t  wr_pos;
    tcw_pkg::cell_t wr_data;
    logic           smem_we;

    always_comb
    begin
        con_idx  = con_reg[tcw_pkg::CON_W-1:0];
        con_ok   = {1'b0, con_reg} < tcw_pkg::con_wide_t'(tcw_pkg::CONSOLES);
        cur_col  = cur_col_reg[con_idx];
        cur_row  = cur_row_reg[con_idx];
        col_last = cur_col == tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1);
        row_last = cur_row == tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
        cur_pos  = tcw_pkg::pos_t'(cur_row) * tcw_pkg::pos_t'(tcw_pkg::COLUMNS)
                 + tcw_pkg::pos_t'(cur_col);
        in_pos   = tcw_pkg::pos_t'(row_reg[tcw_pkg::ROW_W-1:0])
                 * tcw_pkg::pos_t'(tcw_pkg::COLUMNS)
                 + tcw_pkg::pos_t'(col_reg[tcw_pkg::COL_W-1:0]);
        cnt_pos  = cnt_reg[tcw_pkg::POS_W-1:0];
        // Scroll reads one line ahead of where it writes
        rd_pos   = ctrl.rd_ahead ? cnt_pos + tcw_pkg::pos_t'(tcw_pkg::COLUMNS) : cnt_pos;

        unique case (ctrl.src)
            tcw_pkg::SRC_CURSOR:
            begin
                wr_addr = {con_idx, cur_pos};
                wr_data = cell_reg;
            end
            tcw_pkg::SRC_POSITION:
            begin
                wr_addr = {con_idx, in_pos};
                wr_data = cell_reg;
            end
            tcw_pkg::SRC_COPY:
            begin
                wr_addr = {con_idx, cnt_pos};
                wr_data = cmem_rdata_reg;
            end
            tcw_pkg::SRC_BLANK:
            begin
                wr_addr = cnt_reg;
                wr_data = tcw_pkg::BLANK_CELL;
            end
        endcase
        wr_pos = wr_addr[tcw_pkg::POS_W-1:0];

        // Mirror writes only while the console is the one on screen; SM_ALWAYS writes always
        unique case (ctrl.smode)
            tcw_pkg::SM_NONE:   smem_we = 1'b0;
            tcw_pkg::SM_MIRROR: smem_we = con_idx == active_reg;
            tcw_pkg::SM_ALWAYS: smem_we = 1'b1;
            default:            smem_we = 1'b0;
        endcase

        unique case (ctrl.cnt_op)
            tcw_pkg::CNT_HOLD:  cnt_next = cnt_reg;
            tcw_pkg::CNT_CLEAR: cnt_next = '0;
            tcw_pkg::CNT_INC:   cnt_next = cnt_reg + tcw_pkg::addr_t'(1);
            default:            cnt_next = cnt_reg;
        endcase

        // Wrap at end of line; the bottom line stays put and the store scrolls
        if (col_last)
        begin
            cur_col_next = '0;
            cur_row_next = row_last ? cur_row : cur_row + tcw_pkg::row_t'(1);
        end
        else
        begin
            cur_col_next = cur_col + tcw_pkg::col_t'(1);
            cur_row_next = cur_row;
        end

        active_next = ctrl.set_active ? con_idx : active_reg;
    end

    always_comb
    begin
        status.cmd         = command;
        status.con_ok      = {1'b0, console} < tcw_pkg::con_wide_t'(tcw_pkg::CONSOLES);
        status.pos_ok      = (column < tcw_pkg::coord_t'(tcw_pkg::COLUMNS))
                          && (row < tcw_pkg::coord_t'(tcw_pkg::ROWS));
        status.need_scroll = col_last && row_last;
        status.scroll_more = cnt_pos != tcw_pkg::pos_t'(tcw_pkg::SCROLL_CELLS - 1);
        status.load_more   = cnt_pos != tcw_pkg::pos_t'(tcw_pkg::PLANE - 1);
        status.clear_more  = cnt_reg != '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= '0;
            for (int i = 0; i < tcw_pkg::SLOTS; i++)
            begin
                cur_col_reg[i] <= '0;
                cur_row_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            if (ctrl.cur_adv)
            begin
                cur_col_reg[con_idx] <= cur_col_next;
                cur_row_reg[con_idx] <= cur_row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmem_we)
        begin
            cmem_mem[wr_addr] <= wr_data;
        end
        if (ctrl.cmem_re)
        begin
            cmem_rdata_reg <= cmem_mem[{con_idx, rd_pos}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            smem_mem[wr_pos] <= wr_data;
        end
        if (ctrl.smem_re)
        begin
            smem_rdata_reg <= smem_mem[in_pos];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            con_reg   <= console;
            col_reg   <= column;
            row_reg   <= row;
            cell_reg  <= {color_attr, glyph_code};
            glyph_reg <= '0;
            color_reg <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.cap_read)
            begin
                glyph_reg <= smem_rdata_reg[tcw_pkg::BYTE_W-1:0];
                color_reg <= smem_rdata_reg[2*tcw_pkg::BYTE_W-1:tcw_pkg::BYTE_W];
            end
            if (ctrl.set_acc)
            begin
                acc_reg <= 1'b1;
            end
        end
        if (emit)
        begin
            out_glyph_reg <= glyph_reg;
            out_color_reg <= color_reg;
            out_col_reg   <= con_ok ? tcw_pkg::cur_col_t'(cur_col) : '0;
            out_line_reg  <= con_ok ? tcw_pkg::cur_line_t'(cur_row) : '0;
            out_shown_reg <= tcw_pkg::shown_t'(active_reg);
            out_acc_reg   <= acc_reg;
        end
    end

    assign cell_glyph    = out_glyph_reg;
    assign cell_color    = out_color_reg;
    assign cursor_col    = out_col_reg;
    assign cursor_line   = out_line_reg;
    assign shown_console = out_shown_reg;
    assign accepted      = out_acc_reg;

endmodule

[rtl/text_console_writer.sv]
// Top level of the multi-console text writer: handshake control around the sequencer
// and datapath. Depends on tcw_pkg, tcw_if, tcw_sequencer and tcw_datapath.
//
// Usage
//   req carries one command word per valid/ready handshake: put at cursor, put at
//   position, select the shown console, or read a screen cell. rsp returns exactly
//   one word per command: the cell read (zero otherwise), the addressed console's
//   cursor after the command, the shown console and an accepted flag.
//   Steps each command runs after acceptance, before the idle step takes a word:
//     rejected command ............ none, straight back to idle
//     put at cursor / position .... one cell write
//     screen read ................. screen-store read, then capture
//     select ...................... 2000 cells, one read and one write per cell
//     put at cursor that scrolls .. write, then copy 1920 cells in console store
//   The copies are limited by the single read port of the console store.
//   After reset both stores are swept to blank cells, one entry a cycle, over all
//   2^(console bits + position bits) = 16384 addresses; req.ready stays low meanwhile.
//   A finished word sits in the rsp register; while rsp stalls, the next command is
//   still taken, and its result waits in the datapath until the register frees up.
module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    tcw_cmd_if.sink     req,
    tcw_cell_if.source  rsp
);

    tcw_pkg::ctrl_t   ctrl;
    tcw_pkg::status_t status;

    logic pending_reg;
    logic pending_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic accept;
    logic emit;

    // Take a word only in the idle step, and only if the previous result can move out
    always_comb
    begin
        out_free       = !out_valid_reg || rsp.ready;
        req.ready      = ctrl.take && (!pending_reg || out_free);
        accept         = req.valid && req.ready;
        emit           = ctrl.take && pending_reg && out_free;
        pending_next   = accept ? 1'b1 : (emit ? 1'b0 : pending_reg);
        out_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid = out_valid_reg;

    tcw_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .accept (accept),
        .ctrl   (ctrl)
    );

    tcw_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .accept        (accept),
        .emit          (emit),
        .command       (tcw_pkg::cmd_t'(req.command)),
        .console       (req.console),
        .column        (req.column),
        .row           (req.row),
        .glyph_code    (req.glyph_code),
        .color_attr    (req.color_attr),
        .status        (status),
        .cell_glyph    (rsp.cell_glyph),
        .cell_color    (rsp.cell_color),
        .cursor_col    (rsp.cursor_col),
        .cursor_line   (rsp.cursor_line),
        .shown_console (rsp.shown_console),
        .accepted      (rsp.accepted)
    );

endmodule

[rtl/tcw_checker.sv]
// Port-level checks on the result channel of the text console writer, bound to the top.
// Depends on tcw_pkg for geometry.
module tcw_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input tcw_pkg::byte_t       rsp_cell_glyph,
    input tcw_pkg::byte_t       rsp_cell_color,
    input tcw_pkg::cur_col_t    rsp_cursor_col,
    input tcw_pkg::cur_line_t   rsp_cursor_line,
    input tcw_pkg::shown_t      rsp_shown_console,
    input logic                 rsp_accepted
);

    // Hold a stalled result word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({rsp_cell_glyph, rsp_cell_color, rsp_cursor_col,
                        rsp_cursor_line, rsp_shown_console, rsp_accepted}))
        else $error("result word changed while stalled");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> int'(rsp_cursor_col) < tcw_pkg::COLUMNS)
        else $error("cursor column past end of line");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> int'(rsp_cursor_line) < tcw_pkg::ROWS)
        else $error("cursor line past last row");

    // A rejected command never reports cell contents
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_accepted |-> rsp_cell_glyph == '0 && rsp_cell_color == '0)
        else $error("rejected command returned cell data");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_cell_glyph    (rsp.cell_glyph),
    .rsp_cell_color    (rsp.cell_color),
    .rsp_cursor_col    (rsp.cursor_col),
    .rsp_cursor_line   (rsp.cursor_line),
    .rsp_shown_console (rsp.shown_console),
    .rsp_accepted      (rsp.accepted)
);

[test/text_console_writer_tb.sv]
// Self-checking testbench for text_console_writer: drives command words on req, checks
// every rsp word against an in-bench model of the consoles, the screen and the cursors.
// Depends on tcw_pkg, the tcw_cmd_if / tcw_cell_if interfaces and the RTL top level.
`timescale 1ns / 1ps

module text_console_writer_tb;

    // Longest quiet stretch of a correct run is the blank sweep after reset;
    // a select and the deliberate receiver hold are shorter.
    // Allow several times the worst of these.
    localparam int QUIET_LIMIT = 80000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS = 630;

    // One rsp word as the model predicts it
    typedef struct packed {
        tcw_pkg::byte_t     glyph;
        tcw_pkg::byte_t     color;
        tcw_pkg::cur_col_t  cur_col;
        tcw_pkg::cur_line_t cur_line;
        tcw_pkg::shown_t    shown;
        logic               accepted;
    } screen_word_t;

    logic clk = 1'b0;
    logic rst_n;

    tcw_cmd_if  req_bus ();
    tcw_cell_if rsp_bus ();

    text_console_writer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model of the block: every console store, the screen mirror, cursors
    tcw_pkg::cell_t console_cells [tcw_pkg::CONSOLES][tcw_pkg::PLANE];
    tcw_pkg::cell_t screen_cells [tcw_pkg::PLANE];
    int             cursor_x [tcw_pkg::CONSOLES];
    int             cursor_y [tcw_pkg::CONSOLES];
    int             shown_idx;

    screen_word_t screen_replies [$];

    int  error_count = 0;
    int  words_sent = 0;
    int  reads_checked = 0;
    int  wrap_count = 0;
    int  switch_count = 0;
    int  rsp_hold = 0;
    bit  gaps_on = 1'b1;
    int  quiet_cycles = 0;

    function automatic void put_cell(int con, int x, int y, tcw_pkg::cell_t cell_val);
        int pos;
        pos = y * tcw_pkg::COLUMNS + x;
        console_cells[con][pos] = cell_val;
        if (con == shown_idx)
            screen_cells[pos] = cell_val;
    endfunction

    function automatic void reload_screen(int con);
        for (int i = 0; i < tcw_pkg::PLANE; i++)
            screen_cells[i] = console_cells[con][i];
    endfunction

    // Apply one command word to the model and return the word the block owes
    function automatic screen_word_t apply_command(tcw_pkg::cmd_t c,
                                                   tcw_pkg::console_id_t con,
                                                   tcw_pkg::coord_t col,
                                                   tcw_pkg::coord_t row,
                                                   tcw_pkg::byte_t g,
                                                   tcw_pkg::byte_t a);
        screen_word_t   w;
        logic           con_ok;
        logic           pos_ok;
        tcw_pkg::cell_t cell_val;
        w = '0;
        con_ok = (con < tcw_pkg::CONSOLES);
        pos_ok = (col < tcw_pkg::COLUMNS) && (row < tcw_pkg::ROWS);
        cell_val = {a, g};
        case (c)
            tcw_pkg::CMD_PUT_CURSOR:
            begin
                if (con_ok)
                begin
                    put_cell(con, cursor_x[con], cursor_y[con], cell_val);
                    cursor_x[con]++;
                    if (cursor_x[con] >= tcw_pkg::COLUMNS)
                    begin
                        cursor_x[con] = 0;
                        cursor_y[con]++;
                        wrap_count++;
                        if (cursor_y[con] >= tcw_pkg::ROWS)
                        begin
                            // Scroll up one line; the bottom line keeps its old cells
                            cursor_y[con] = tcw_pkg::ROWS - 1;
                            for (int i = 0; i < tcw_pkg::SCROLL_CELLS; i++)
                                console_cells[con][i] =
                                    console_cells[con][i + tcw_pkg::COLUMNS];
                            if (con == shown_idx)
                                reload_screen(con);
                        end
                    end
                    w.accepted = 1'b1;
                end
            end
            tcw_pkg::CMD_PUT_POS:
            begin
                if (con_ok && pos_ok)
                begin
                    put_cell(con, col, row, cell_val);
                    w.accepted = 1'b1;
                end
            end
            tcw_pkg::CMD_SELECT:
            begin
                if (con_ok)
                begin
                    shown_idx = con;
                    reload_screen(con);
                    switch_count++;
                    w.accepted = 1'b1;
                end
            end
            default:
            begin
                // The console field does not gate a read; only the position does
                if (pos_ok)
                begin
                    cell_val = screen_cells[row * tcw_pkg::COLUMNS + col];
                    w.glyph = cell_val[7:0];
                    w.color = cell_val[15:8];
                    w.accepted = 1'b1;
                    reads_checked++;
                end
            end
        endcase
        if (con_ok)
        begin
            w.cur_col = tcw_pkg::cur_col_t'(cursor_x[con]);
            w.cur_line = tcw_pkg::cur_line_t'(cursor_y[con]);
        end
        w.shown = tcw_pkg::shown_t'(shown_idx);
        return w;
    endfunction

    // Gap length for either side: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    // Offer one command word and hold it until the block takes it
    task automatic send_word(input tcw_pkg::cmd_t c, input int con, input int col,
                             input int row, input int g, input int a);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.command = c;
        req_bus.console = tcw_pkg::console_id_t'(con);
        req_bus.column = tcw_pkg::coord_t'(col);
        req_bus.row = tcw_pkg::coord_t'(row);
        req_bus.glyph_code = tcw_pkg::byte_t'(g);
        req_bus.color_attr = tcw_pkg::byte_t'(a);
        req_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        screen_replies.push_back(apply_command(c, tcw_pkg::console_id_t'(con),
                                               tcw_pkg::coord_t'(col),
                                               tcw_pkg::coord_t'(row),
                                               tcw_pkg::byte_t'(g),
                                               tcw_pkg::byte_t'(a)));
        words_sent++;
    endtask

    // Random word: favors the shown console and the top rows so reads hit written cells
    task automatic send_random_word();
        int r;
        int con;
        int col;
        int row;
        tcw_pkg::cmd_t c;
        r = $urandom_range(99);
        if (r < 38)
            c = tcw_pkg::CMD_PUT_CURSOR;
        else if (r < 63)
            c = tcw_pkg::CMD_PUT_POS;
        else if (r < 66)
            c = tcw_pkg::CMD_SELECT;
        else
            c = tcw_pkg::CMD_READ;
        r = $urandom_range(99);
        if (r < 12)
            con = $urandom_range(tcw_pkg::CONSOLES, 15);
        else if (r < 60)
            con = shown_idx;
        else
            con = $urandom_range(0, tcw_pkg::CONSOLES - 1);
        r = $urandom_range(99);
        if (r < 5)
        begin
            col = $urandom_range(tcw_pkg::COLUMNS, 255);
            row = $urandom_range(0, 255);
        end
        else if (r < 10)
        begin
            col = $urandom_range(0, 255);
            row = $urandom_range(tcw_pkg::ROWS, 255);
        end
        else if (r < 55)
        begin
            col = $urandom_range(0, tcw_pkg::COLUMNS - 1);
            row = $urandom_range(0, 3);
        end
        else
        begin
            col = $urandom_range(0, tcw_pkg::COLUMNS - 1);
            row = $urandom_range(0, tcw_pkg::ROWS - 1);
        end
        send_word(c, con, col, row, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // Corners, rejected positions and consoles, every command, mirror on and off
    task automatic test_directed_cases();
        send_word(tcw_pkg::CMD_READ, 0, 0, 0, 0, 0);
        send_word(tcw_pkg::CMD_READ, 15, tcw_pkg::COLUMNS - 1, tcw_pkg::ROWS - 1, 0, 0);
        send_word(tcw_pkg::CMD_READ, 0, tcw_pkg::COLUMNS, 0, 0, 0);
        send_word(tcw_pkg::CMD_READ, 0, 0, tcw_pkg::ROWS, 0, 0);
        send_word(tcw_pkg::CMD_READ, 0, 255, 255, 0, 0);
        send_word(tcw_pkg::CMD_PUT_CURSOR, 0, 0, 0, 8'hFF, 8'hFF);
        send_word(tcw_pkg::CMD_PUT_CURSOR, 0, 0, 0, 8'h00, 8'h00);
        send_word(tcw_pkg::CMD_READ, 0, 0, 0, 0, 0);
        send_word(tcw_pkg::CMD_READ, 0, 1, 0, 0, 0);
        send_word(tcw_pkg::CMD_PUT_POS, 0, tcw_pkg::COLUMNS - 1, tcw_pkg::ROWS - 1,
                  8'hA5, 8'h5A);
        send_word(tcw_pkg::CMD_READ, 0, tcw_pkg::COLUMNS - 1, tcw_pkg::ROWS - 1, 0, 0);
        send_word(tcw_pkg::CMD_PUT_POS, 0, tcw_pkg::COLUMNS, 0, 8'h11, 8'h22);
        send_word(tcw_pkg::CMD_PUT_POS, 0, 0, tcw_pkg::ROWS, 8'h33, 8'h44);
        send_word(tcw_pkg::CMD_PUT_POS, 0, 255, 255, 8'h55, 8'h66);
        send_word(tcw_pkg::CMD_PUT_CURSOR, tcw_pkg::CONSOLES, 0, 0, 8'h77, 8'h88);
        send_word(tcw_pkg::CMD_PUT_POS, 15, 1, 1, 8'h99, 8'hAA);
        send_word(tcw_pkg::CMD_SELECT, tcw_pkg::CONSOLES, 0, 0, 0, 0);
        // Write a hidden console; the screen must not change
        send_word(tcw_pkg::CMD_PUT_POS, tcw_pkg::CONSOLES - 1, 0, 0, 8'h41, 8'h1E);
        send_word(tcw_pkg::CMD_READ, 0, 0, 0, 0, 0);
        send_word(tcw_pkg::CMD_SELECT, tcw_pkg::CONSOLES - 1, 0, 0, 0, 0);
        send_word(tcw_pkg::CMD_READ, tcw_pkg::CONSOLES - 1, 0, 0, 0, 0);
        send_word(tcw_pkg::CMD_READ, tcw_pkg::CONSOLES - 1, tcw_pkg::COLUMNS - 1,
                  tcw_pkg::ROWS - 1, 0, 0);
        send_word(tcw_pkg::CMD_SELECT, 0, 0, 0, 0, 0);
        send_word(tcw_pkg::CMD_READ, 0, tcw_pkg::COLUMNS - 1, tcw_pkg::ROWS - 1, 0, 0);
    endtask

    // Hold rsp off for a long stretch while req keeps offering words back to back
    task automatic test_backpressure();
        gaps_on = 1'b0;
        rsp_hold = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_word(tcw_pkg::CMD_PUT_POS, shown_idx,
                      $urandom_range(0, tcw_pkg::COLUMNS - 1), $urandom_range(0, 3),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        gaps_on = 1'b1;
    endtask

    // Write one console through the cursor across two line ends, then read back
    task automatic test_line_wrap(input int con);
        int n;
        n = 2 * tcw_pkg::COLUMNS - cursor_x[con] + 5;
        for (int i = 0; i < n; i++)
            send_word(tcw_pkg::CMD_PUT_CURSOR, con, 0, 0, $urandom_range(0, 255),
                      $urandom_range(0, 255));
        if (con != shown_idx)
            send_word(tcw_pkg::CMD_SELECT, con, 0, 0, 0, 0);
        for (int i = 0; i < 20; i++)
            send_word(tcw_pkg::CMD_READ, con, $urandom_range(0, tcw_pkg::COLUMNS - 1),
                      $urandom_range(0, 3), 0, 0);
    endtask

    // Random mix in blocks; every third block runs without gaps on either side
    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            gaps_on = ((i / 150) % 3) != 2;
            send_random_word();
        end
        gaps_on = 1'b1;
    endtask

    // Drain rsp: random stalls, plus a long counted hold on request
    initial
    begin : rsp_drain
        int stall_left;
        int g;
        stall_left = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                stall_left = rsp_hold;
                rsp_hold = 0;
            end
            if (stall_left > 0)
            begin
                rsp_bus.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    rsp_bus.ready = 1'b0;
                    stall_left = g - 1;
                end
                else
                    rsp_bus.ready = 1'b1;
            end
        end
    end

    // Compare each taken rsp word with the oldest prediction
    always @(posedge clk)
    begin
        screen_word_t want;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (screen_replies.size() == 0)
            begin
                $error("rsp word with no command outstanding");
                error_count++;
            end
            else
            begin
                want = screen_replies.pop_front();
                check_field("cell_glyph", want.glyph, rsp_bus.cell_glyph);
                check_field("cell_color", want.color, rsp_bus.cell_color);
                check_field("cursor_col", want.cur_col, rsp_bus.cursor_col);
                check_field("cursor_line", want.cur_line, rsp_bus.cursor_line);
                check_field("shown_console", want.shown, rsp_bus.shown_console);
                check_field("accepted", want.accepted, rsp_bus.accepted);
            end
        end
    end

    // Watchdog: count cycles with no word taken on either channel
    always @(posedge clk)
    begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        req_bus.valid = 1'b0;
        req_bus.command = tcw_pkg::CMD_PUT_CURSOR;
        req_bus.console = '0;
        req_bus.column = '0;
        req_bus.row = '0;
        req_bus.glyph_code = '0;
        req_bus.color_attr = '0;
        for (int c = 0; c < tcw_pkg::CONSOLES; c++)
        begin
            for (int i = 0; i < tcw_pkg::PLANE; i++)
                console_cells[c][i] = tcw_pkg::BLANK_CELL;
            cursor_x[c] = 0;
            cursor_y[c] = 0;
        end
        for (int i = 0; i < tcw_pkg::PLANE; i++)
            screen_cells[i] = tcw_pkg::BLANK_CELL;
        shown_idx = 0;

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_backpressure();
        test_line_wrap(shown_idx);
        test_line_wrap(3);
        send_word(tcw_pkg::CMD_SELECT, 0, 0, 0, 0, 0);
        test_random_mix();

        @(negedge clk);
        req_bus.valid = 1'b0;
        while (screen_replies.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("summary: %0d command words, %0d in-range screen reads, %0d line wraps,",
                 words_sent, reads_checked, wrap_count);
        $display("summary: %0d console switches, %0d mismatches", switch_count, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_sequencer.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
test/text_console_writer_tb.sv
